[sv/smc_pkg.sv]
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, constants and helpers of the servo motion sequencer.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int FifoDepthDef = 16;
    localparam int AngleMax     = 180;
    localparam int PwmOffset    = 45;
    // 16383 / 1800 scaled by 2^19 and rounded up; floor(x * PwmRecip >> PwmShift)
    // equals floor(16383 * x / 1800) for every x up to 225.
    localparam int PwmRecip     = 4771895;
    localparam int PwmShift     = 19;
    localparam int DivW         = 22;
    localparam int DsrW         = 13;

    localparam logic [2:0] CFG_LOWEST  = 3'd0;
    localparam logic [2:0] CFG_HIGHEST = 3'd1;
    localparam logic [2:0] CFG_HOME    = 3'd2;
    localparam logic [2:0] CFG_MOVE    = 3'd3;
    localparam logic [2:0] CFG_MINSTEP = 3'd4;
    localparam logic [2:0] CFG_PAUSE   = 3'd5;

    localparam logic [2:0] FN_TICK  = 3'd0;
    localparam logic [2:0] FN_SET   = 3'd1;
    localparam logic [2:0] FN_CW    = 3'd2;
    localparam logic [2:0] FN_CCW   = 3'd3;
    localparam logic [2:0] FN_SWEEP = 3'd4;
    localparam logic [2:0] FN_STOP  = 3'd5;
    localparam logic [2:0] FN_RESET = 3'd6;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  arg_a;
        logic [7:0]  arg_b;
        logic [12:0] arg_speed;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  angle_now;
        logic [13:0] pwm_compare;
        logic        pwm_update;
        logic        moving_flag;
        logic        sweeping_flag;
        logic        move_done;
        logic        cmd_accepted;
        logic        cmd_dropped;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  lowest;
        logic [7:0]  highest;
        logic [7:0]  home;
        logic [12:0] move_time;
        logic [7:0]  min_step;
        logic [9:0]  pause;
    } cfg_t;

    typedef enum logic [1:0] {K_TICK, K_STOP, K_CMD, K_BAD} kind_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t cmd;
    } entry_t;

    // Limits an angle to the configured window; the lower limit wins.
    function automatic logic [7:0] clamp_angle(logic signed [9:0] a, cfg_t c);
        logic [7:0] r;
        if (a < $signed({2'b00, c.lowest}))
        begin
            r = c.lowest;
        end
        else if (a > $signed({2'b00, c.highest}))
        begin
            r = c.highest;
        end
        else
        begin
            r = a[7:0];
        end
        return r;
    endfunction

endpackage

[sv/smc_ram.sv]
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/smc_div.sv]
// ----------------------------------------------------------------------------
// smc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smc_div
    import smc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DivW-1:0] dividend,
    input  logic [DsrW-1:0] divisor,
    output logic            done,
    output logic [DivW-1:0] quotient
);
    localparam int CntW = $clog2(DivW + 1);

    logic [CntW-1:0] cnt_reg;
    logic [DsrW-1:0] rem_reg;
    logic [DsrW-1:0] dsr_reg;
    logic [DivW-1:0] quo_reg;
    logic            done_reg;
    logic [DsrW:0]   rem_sh;
    logic [DsrW:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[DivW-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CntW'(DivW);
                rem_reg <= '0;
                dsr_reg <= divisor;
                quo_reg <= dividend;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (rem_sh >= {1'b0, dsr_reg})
                begin
                    rem_reg <= rem_sub[DsrW-1:0];
                    quo_reg <= {quo_reg[DivW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DsrW-1:0];
                    quo_reg <= {quo_reg[DivW-2:0], 1'b0};
                end
                if (cnt_reg == CntW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[sv/smc_front.sv]
// ----------------------------------------------------------------------------
// smc_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module smc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  smc_pkg::in_item_t in_data,
    input  smc_pkg::cfg_t     cfg,
    output logic              q_valid,
    output smc_pkg::entry_t   q_entry,
    input  logic              q_pop
);
    import smc_pkg::*;

    entry_t     slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    entry_t     cls;
    logic       push;

    always_comb
    begin
        cls.cmd  = in_data;
        cls.kind = K_CMD;
        unique case (in_data.func)
            FN_TICK: cls.kind = K_TICK;
            FN_STOP: cls.kind = K_STOP;
            FN_CW, FN_CCW:
            begin
                if (in_data.arg_a == '0)
                begin
                    cls.kind = K_BAD;
                end
            end
            FN_SWEEP:
            begin
                if (in_data.arg_a < cfg.lowest || in_data.arg_a > cfg.highest ||
                    in_data.arg_b < cfg.lowest || in_data.arg_b > cfg.highest ||
                    in_data.arg_a >= in_data.arg_b)
                begin
                    cls.kind = K_BAD;
                end
            end
            FN_SET, FN_RESET: cls.kind = K_CMD;
            default: cls.kind = K_BAD;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_entry  = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wp_reg] <= cls;
                wp_reg           <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

[sv/smc_back.sv]
// ----------------------------------------------------------------------------
// smc_back
// Executes classified items: command queue, motion sequencing, result beats.
// ----------------------------------------------------------------------------
module smc_back #(
    parameter int FIFO_DEPTH = smc_pkg::FifoDepthDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smc_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  smc_pkg::entry_t    q_entry,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output smc_pkg::out_item_t out_data
);
    import smc_pkg::*;

    localparam int AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW    = $clog2(FIFO_DEPTH + 1);
    localparam int ProdW = PwmShift + 14;

    typedef enum logic [2:0] {
        S_IDLE, S_POP, S_PLAN, S_DIV, S_PWM, S_OUT
    } state_t;
    typedef enum logic [1:0] {PH_IDLE, PH_MOVE, PH_SWEEP, PH_PAUSE} phase_t;

    state_t          state_reg;
    phase_t          phase_reg;
    logic [7:0]      cur_reg;
    logic [7:0]      goal_reg;
    logic [12:0]     wc_reg;
    logic [12:0]     si_reg;
    logic [15:0]     bounds_reg;
    logic [12:0]     leg_reg;
    logic            tmax_reg;
    logic [12:0]     budget_reg;
    logic            legmode_reg;
    logic [AW-1:0]   head_reg;
    logic [AW-1:0]   tail_reg;
    logic [CW-1:0]   cnt_reg;
    logic            upd_reg;
    logic            done_reg;
    logic            acc_reg;
    logic            drop_reg;
    logic [13:0]     pwm_reg;
    logic            out_valid_reg;
    out_item_t       out_reg;
    logic            div_start_reg;
    logic [DivW-1:0] div_a_reg;
    logic [DsrW-1:0] div_b_reg;

    logic            div_done;
    logic [DivW-1:0] div_q;
    in_item_t        rdata;
    logic            ram_we;
    logic [12:0]     wc_dec;
    logic [7:0]      steps;
    logic [7:0]      leg_goal;
    logic [7:0]      pop_goal;
    logic [7:0]      step_ang;
    logic [7:0]      ms;
    logic [12:0]     si_new;
    logic [8:0]      pwm_base;
    logic [ProdW-1:0] pwm_prod;
    logic signed [9:0] tgt;

    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign ram_we = q_pop && (q_entry.kind == K_CMD) && (cnt_reg < CW'(FIFO_DEPTH));

    smc_ram #(.WIDTH($bits(in_item_t)), .DEPTH(FIFO_DEPTH), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (q_entry.cmd),
        .raddr (head_reg),
        .rdata (rdata)
    );

    smc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        wc_dec   = (wc_reg != '0) ? wc_reg - 13'd1 : 13'd0;
        steps    = (cur_reg > goal_reg) ? cur_reg - goal_reg : goal_reg - cur_reg;
        step_ang = (cur_reg < goal_reg) ? cur_reg + 8'd1 : cur_reg - 8'd1;
        leg_goal = clamp_angle($signed({2'b00, tmax_reg ? bounds_reg[15:8]
                                                        : bounds_reg[7:0]}), cfg);
        unique case (rdata.func)
            FN_CW:    tgt = $signed({2'b00, cur_reg}) + $signed({2'b00, rdata.arg_a});
            FN_CCW:   tgt = $signed({2'b00, cur_reg}) - $signed({2'b00, rdata.arg_a});
            FN_RESET: tgt = $signed({2'b00, cfg.home});
            default:  tgt = $signed({2'b00, rdata.arg_a});
        endcase
        pop_goal = clamp_angle(tgt, cfg);
        ms       = (cfg.min_step == '0) ? 8'd1 : cfg.min_step;
        si_new   = (div_q[12:0] < {5'd0, ms}) ? {5'd0, ms} : div_q[12:0];
        pwm_base = 9'(PwmOffset) + {1'b0, cur_reg};
        // 16383 * x / 1800 by multiplying with a scaled reciprocal.
        pwm_prod = ProdW'(pwm_base) * ProdW'(PwmRecip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            cur_reg       <= 8'd90;
            goal_reg      <= 8'd90;
            wc_reg        <= '0;
            si_reg        <= '0;
            bounds_reg    <= '0;
            leg_reg       <= '0;
            tmax_reg      <= 1'b1;
            budget_reg    <= '0;
            legmode_reg   <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            upd_reg       <= 1'b0;
            done_reg      <= 1'b0;
            acc_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        upd_reg   <= 1'b0;
                        done_reg  <= 1'b0;
                        acc_reg   <= 1'b0;
                        drop_reg  <= 1'b0;
                        state_reg <= S_PWM;
                        unique case (q_entry.kind)
                            K_BAD: drop_reg <= 1'b1;
                            K_CMD:
                            begin
                                if (ram_we)
                                begin
                                    acc_reg  <= 1'b1;
                                    cnt_reg  <= cnt_reg + 1'b1;
                                    tail_reg <= (tail_reg == AW'(FIFO_DEPTH - 1))
                                                ? '0 : tail_reg + 1'b1;
                                end
                                else
                                begin
                                    drop_reg <= 1'b1;
                                end
                            end
                            K_STOP:
                            begin
                                acc_reg   <= 1'b1;
                                cnt_reg   <= '0;
                                head_reg  <= tail_reg;
                                done_reg  <= (phase_reg != PH_IDLE);
                                phase_reg <= PH_IDLE;
                                wc_reg    <= '0;
                            end
                            K_TICK:
                            begin
                                if (phase_reg == PH_IDLE)
                                begin
                                    if (cnt_reg != '0)
                                    begin
                                        cnt_reg   <= cnt_reg - 1'b1;
                                        head_reg  <= (head_reg == AW'(FIFO_DEPTH - 1))
                                                     ? '0 : head_reg + 1'b1;
                                        state_reg <= S_POP;
                                    end
                                end
                                else if (wc_dec != '0)
                                begin
                                    wc_reg <= wc_dec;
                                end
                                else if (phase_reg == PH_PAUSE)
                                begin
                                    wc_reg      <= wc_dec;
                                    goal_reg    <= leg_goal;
                                    budget_reg  <= leg_reg;
                                    legmode_reg <= 1'b1;
                                    state_reg   <= S_PLAN;
                                end
                                else if (cur_reg != goal_reg)
                                begin
                                    cur_reg <= step_ang;
                                    wc_reg  <= si_reg;
                                    upd_reg <= 1'b1;
                                end
                                else
                                begin
                                    upd_reg <= 1'b1;
                                    if (phase_reg == PH_MOVE)
                                    begin
                                        wc_reg    <= wc_dec;
                                        phase_reg <= PH_IDLE;
                                        done_reg  <= 1'b1;
                                    end
                                    else
                                    begin
                                        tmax_reg  <= ~tmax_reg;
                                        phase_reg <= PH_PAUSE;
                                        wc_reg    <= {3'd0, cfg.pause};
                                    end
                                end
                            end
                            default: drop_reg <= 1'b1;
                        endcase
                    end
                end
                S_POP:
                begin
                    state_reg <= S_PLAN;
                    if (rdata.func == FN_SWEEP)
                    begin
                        bounds_reg  <= {rdata.arg_b, rdata.arg_a};
                        leg_reg     <= rdata.arg_speed;
                        tmax_reg    <= 1'b1;
                        goal_reg    <= clamp_angle($signed({2'b00, rdata.arg_b}), cfg);
                        budget_reg  <= rdata.arg_speed;
                        legmode_reg <= 1'b1;
                    end
                    else
                    begin
                        goal_reg    <= pop_goal;
                        budget_reg  <= cfg.move_time;
                        legmode_reg <= 1'b0;
                    end
                end
                S_PLAN:
                begin
                    if (steps == '0)
                    begin
                        state_reg <= S_PWM;
                        if (legmode_reg)
                        begin
                            tmax_reg  <= ~tmax_reg;
                            phase_reg <= PH_PAUSE;
                            wc_reg    <= {3'd0, cfg.pause};
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        div_a_reg     <= {9'd0, budget_reg};
                        div_b_reg     <= {5'd0, steps};
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        si_reg    <= si_new;
                        wc_reg    <= si_new;
                        cur_reg   <= step_ang;
                        upd_reg   <= 1'b1;
                        phase_reg <= legmode_reg ? PH_SWEEP : PH_MOVE;
                        state_reg <= S_PWM;
                    end
                end
                S_PWM:
                begin
                    pwm_reg   <= pwm_prod[PwmShift+13:PwmShift];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.angle_now     <= cur_reg;
                        out_reg.pwm_compare   <= pwm_reg;
                        out_reg.pwm_update    <= upd_reg;
                        out_reg.moving_flag   <= (phase_reg != PH_IDLE);
                        out_reg.sweeping_flag <= (phase_reg == PH_SWEEP) ||
                                                 (phase_reg == PH_PAUSE);
                        out_reg.move_done     <= done_reg;
                        out_reg.cmd_accepted  <= acc_reg;
                        out_reg.cmd_dropped   <= drop_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

[sv/servo_motion_sequencer_top.sv]
// ----------------------------------------------------------------------------
// servo_motion_sequencer_top
// A command or idle tick goes through S_IDLE, S_PWM and S_OUT before its result
// beat is registered; a tick that starts a move or sweep leg also passes S_POP
// (for a queued command), S_PLAN and S_DIV, where the 22-step step-interval
// divider runs. A new item is taken only after the last result beat is registered.
// Reset (rst_n, asynchronous, low) clears the queues and motion state, parks the
// servo at the home angle and loads the register defaults.
// ----------------------------------------------------------------------------
module servo_motion_sequencer_top #(
    parameter int FIFO_DEPTH = smc_pkg::FifoDepthDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  smc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output smc_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data
);
    import smc_pkg::*;

    // The configuration registers live here and feed both halves of the block.
    cfg_t       cfg_reg;
    logic [7:0] ang_sat;
    logic       q_valid;
    entry_t     q_entry;
    logic       q_pop;

    // Angle registers saturate at the mechanical end stop when written.
    assign ang_sat   = (cfg_data[7:0] > 8'(AngleMax)) ? 8'(AngleMax) : cfg_data[7:0];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lowest    <= 8'd0;
            cfg_reg.highest   <= 8'd180;
            cfg_reg.home      <= 8'd90;
            cfg_reg.move_time <= 13'd500;
            cfg_reg.min_step  <= 8'd10;
            cfg_reg.pause     <= 10'd100;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOWEST:  cfg_reg.lowest    <= ang_sat;
                CFG_HIGHEST: cfg_reg.highest   <= ang_sat;
                CFG_HOME:    cfg_reg.home      <= ang_sat;
                CFG_MOVE:    cfg_reg.move_time <= cfg_data;
                CFG_MINSTEP: cfg_reg.min_step  <= cfg_data[7:0];
                CFG_PAUSE:   cfg_reg.pause     <= cfg_data[9:0];
                default:     ;
            endcase
        end
    end

    // The front half validates each beat and parks it in a two-entry queue, so
    // up to two input beats are accepted while the back half is busy stepping.
    smc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // The back half owns the command FIFO, the motion sequencer and the
    // output register.
    smc_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A result never reports a command as both accepted and dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.cmd_accepted && out_data.cmd_dropped))
        else $error("result beat both accepted and dropped");

    // Sweeping is a kind of motion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.sweeping_flag) |-> out_data.moving_flag)
        else $error("sweep flag without moving flag");

    // The commanded angle stays within the servo range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.angle_now <= 8'(AngleMax)))
        else $error("angle beyond range");
endmodule
